FILE: rtl/mhpq_pkg.sv
// Shared constants for the max-heap priority queue: sizes, operation kinds and status codes.
// Depends on nothing; imported by the top level.
`default_nettype none

package mhpq_pkg;

    // Heap capacity and entry width.
    localparam int HEAP_DEPTH  = 64;
    localparam int VALUE_WIDTH = 32;

    // Derived widths: heap index and live entry count (count must hold HEAP_DEPTH).
    localparam int ADDR_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);

    // Operation kinds.
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/mhpq_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered read data.
// Depends on nothing; used by the heap top level for the heap store.
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two read ports; read data is registered when the read enable is set.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/max_heap_priority_queue_top.sv
// An insert climbs from the new last position toward the root, moving each smaller parent
// down, and an extract returns the root, takes the last live entry and sifts it down from the
// root, pulling up the larger child; a refused item (full or empty) goes straight to the result.
// Each heap level is handled by a RAM read state and a compare/write state. One item is in work
// at a time, and the input reopens when the sequencer returns to idle after the result is loaded.
// Reset (synchronous, active low) empties the heap and clears the output valid; the RAM contents
// are not cleared, as only entries of the live heap are ever used.
// Depends on mhpq_pkg and mhpq_ram.
`default_nettype none

module max_heap_priority_queue_top
    import mhpq_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_kind,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    // Output channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]      o_result_value,
    output logic        [1:0]                  o_status,
    output logic        [CNT_W-1:0]            o_count_after
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_EX_RD  = 3'd3;
    localparam logic [2:0] S_EX_CMP = 3'd4;
    localparam logic [2:0] S_DN_RD  = 3'd5;
    localparam logic [2:0] S_DN_CMP = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [ADDR_W-1:0]             r_pos, n_pos;
    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic signed [VALUE_WIDTH-1:0] r_result, n_result;
    logic [1:0]                    r_status, n_status;

    // RAM control.
    logic                   w_wr_en;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [VALUE_WIDTH-1:0] w_wr_data;
    logic                   w_rd_en;
    logic [ADDR_W-1:0]      w_rd_addr_a;
    logic [ADDR_W-1:0]      w_rd_addr_b;
    logic [VALUE_WIDTH-1:0] w_rd_data_a;
    logic [VALUE_WIDTH-1:0] w_rd_data_b;

    // Heap neighbor indices of the current position.
    logic [ADDR_W-1:0]             w_parent;
    logic [ADDR_W:0]               w_left;
    logic [ADDR_W+1:0]             w_right;
    logic                          w_right_live;
    logic signed [VALUE_WIDTH-1:0] w_left_val;
    logic signed [VALUE_WIDTH-1:0] w_right_val;
    logic signed [VALUE_WIDTH-1:0] w_big_val;
    logic [ADDR_W-1:0]             w_big_idx;
    logic                          w_fin_load;

    assign w_parent     = (r_pos - ADDR_W'(1)) >> 1;
    assign w_left       = {r_pos, 1'b1};
    assign w_right      = {1'b0, w_left} + (ADDR_W + 2)'(1);
    assign w_right_live = w_right < {1'b0, r_count};
    assign w_left_val   = $signed(w_rd_data_a);
    assign w_right_val  = $signed(w_rd_data_b);

    // Larger child; the right child wins only when strictly greater.
    always_comb begin
        if (w_right_live && (w_right_val > w_left_val)) begin
            w_big_val = w_right_val;
            w_big_idx = w_right[ADDR_W-1:0];
        end else begin
            w_big_val = w_left_val;
            w_big_idx = w_left[ADDR_W-1:0];
        end
    end

    // The result can be loaded when the output register is free or being taken.
    assign w_fin_load = (r_state == S_FIN) && (!o_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer: the moving entry stays in r_val and the hole walks through the heap, so
    // reads and writes never fall in the same cycle and no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_val       = r_val;
        n_result    = r_result;
        n_status    = r_status;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_pos;
        w_wr_data   = r_val;
        w_rd_en     = 1'b0;
        w_rd_addr_a = '0;
        w_rd_addr_b = r_count[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_result = '0;
                    n_status = ST_OK;
                    if (i_kind == KIND_INSERT) begin
                        if (r_count == CNT_W'(HEAP_DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_val   = i_value;
                            n_pos   = r_count[ADDR_W-1:0];
                            n_count = r_count + CNT_W'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_state = S_EX_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                // At the root the new entry settles; otherwise fetch the parent.
                if (r_pos == '0) begin
                    w_wr_en = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_rd_en     = 1'b1;
                    w_rd_addr_a = w_parent;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // Move the parent down while the new entry is strictly greater.
                w_wr_en = 1'b1;
                if (r_val > w_left_val) begin
                    w_wr_data = w_rd_data_a;
                    n_pos     = w_parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_EX_RD: begin
                // Fetch the root and the last live entry.
                w_rd_en     = 1'b1;
                w_rd_addr_a = '0;
                w_rd_addr_b = r_count[ADDR_W-1:0];
                n_state     = S_EX_CMP;
            end
            S_EX_CMP: begin
                n_result = w_left_val;
                n_val    = w_right_val;
                n_pos    = '0;
                n_state  = S_DN_RD;
            end
            S_DN_RD: begin
                // Fetch both children while the position still has a live child.
                if (w_left < r_count) begin
                    w_rd_en     = 1'b1;
                    w_rd_addr_a = w_left[ADDR_W-1:0];
                    w_rd_addr_b = w_right[ADDR_W-1:0];
                    n_state     = S_DN_CMP;
                end else begin
                    w_wr_en = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_DN_CMP: begin
                // Stop when strictly greater than the larger child, else pull it up.
                w_wr_en = 1'b1;
                if (r_val > w_big_val) begin
                    n_state = S_FIN;
                end else begin
                    w_wr_data = w_big_val;
                    n_pos     = w_big_idx;
                    n_state   = S_DN_RD;
                end
            end
            S_FIN: begin
                if (w_fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_result <= n_result;
        r_status <= n_status;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            o_result_value <= r_result;
            o_status       <= r_status;
            o_count_after  <= r_count;
        end
    end

    // Heap store.
    mhpq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_en     (w_rd_en),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    // The live count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HEAP_DEPTH))
        else $error("heap count above capacity");

    // An accepted insert into a heap with room grows the count by one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_kind == KIND_INSERT) &&
         (r_count != CNT_W'(HEAP_DEPTH))) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

    // The sift-down position always lies inside the live heap.
    a_down_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_CMP) |-> ({1'b0, r_pos} < r_count))
        else $error("sift-down position outside live heap");

    // Only a successful extract delivers a nonzero value.
    a_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_result_value == '0))
        else $error("nonzero value on a refused item");

endmodule

`default_nettype wire
